>>> hdl/aat_pkg.sv
// Shared types, register indexes and rounding helper for the box transform.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package aat_pkg;

    localparam int NUM_CFG  = 6;
    localparam int NUM_AXES = 3;
    localparam int CFG_IDX_W = 3;

    // Register indexes, in the order of the register map.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_COLS23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST        = CFG_ROW2_COLS23;

    typedef logic [63:0]        t_cfg;
    typedef logic signed [31:0] t_q16;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [65:0] t_sum;

    // Identity map after reset.
    localparam t_cfg CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    localparam t_q16 Q16_MAX = 32'sh7FFF_FFFF;
    localparam t_q16 Q16_MIN = 32'sh8000_0000;

    // floor(sum / 2^16) + trans, saturated to signed 32 bits
    function automatic t_q16 floor_sat(input t_sum sum, input t_q16 trans);
        logic signed [49:0] shr;
        logic signed [50:0] v;
        t_q16               res;
        shr = sum[65:16];
        v   = 51'({shr[49], shr}) + 51'({{19{trans[31]}}, trans});
        if (v[50:31] == {20{1'b0}} || v[50:31] == {20{1'b1}}) begin
            res = v[31:0];
        end else if (v[50]) begin
            res = Q16_MIN;
        end else begin
            res = Q16_MAX;
        end
        return res;
    endfunction

endpackage

>>> hdl/aat_in_if.sv
// Input channel: one box per transfer, valid/ready handshake.
// Depends on aat_pkg for the coordinate type.
interface aat_in_if;
    logic         valid;
    logic         ready;
    aat_pkg::t_q16 in_lower_x;
    aat_pkg::t_q16 in_lower_y;
    aat_pkg::t_q16 in_lower_z;
    aat_pkg::t_q16 in_upper_x;
    aat_pkg::t_q16 in_upper_y;
    aat_pkg::t_q16 in_upper_z;

    modport source (
        output valid, in_lower_x, in_lower_y, in_lower_z,
        output in_upper_x, in_upper_y, in_upper_z,
        input  ready
    );
    modport sink (
        input  valid, in_lower_x, in_lower_y, in_lower_z,
        input  in_upper_x, in_upper_y, in_upper_z,
        output ready
    );
endinterface

>>> hdl/aat_out_if.sv
// Output channel: one bounding box per transfer, valid/ready handshake.
// Depends on aat_pkg for the coordinate type.
interface aat_out_if;
    logic         valid;
    logic         ready;
    aat_pkg::t_q16 out_lower_x;
    aat_pkg::t_q16 out_lower_y;
    aat_pkg::t_q16 out_lower_z;
    aat_pkg::t_q16 out_upper_x;
    aat_pkg::t_q16 out_upper_y;
    aat_pkg::t_q16 out_upper_z;

    modport source (
        output valid, out_lower_x, out_lower_y, out_lower_z,
        output out_upper_x, out_upper_y, out_upper_z,
        input  ready
    );
    modport sink (
        input  valid, out_lower_x, out_lower_y, out_lower_z,
        input  out_upper_x, out_upper_y, out_upper_z,
        output ready
    );
endinterface

>>> hdl/aat_top.sv
// A box accepted on i_box is shown on o_box once it has passed every register stage.
// Throughput: one box per cycle while o_box is ready; four register stages (input,
// products, min/max sums, rounded result) each advance whenever the next one is free.
// Reset (synchronous, active low) empties the pipeline and loads the identity map.
// Depends on aat_pkg, aat_in_if, aat_out_if, aat_row_mul and aat_row_bound.
module aabb_affine_transform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  aat_pkg::t_cfg                     i_cfg_data,
    aat_in_if.sink                            i_box,
    aat_out_if.source                         o_box
);

    localparam int N = aat_pkg::NUM_AXES;

    aat_pkg::t_cfg r_cfg [aat_pkg::NUM_CFG];

    logic r_v1, r_v2, r_v3, r_vo;
    logic en1, en2, en3, en_o;

    aat_pkg::t_q16 r_lo [N];
    aat_pkg::t_q16 r_hi [N];
    aat_pkg::t_q16 r_out_lo [N];
    aat_pkg::t_q16 r_out_hi [N];
    aat_pkg::t_sum min_sum [N];
    aat_pkg::t_sum max_sum [N];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= aat_pkg::CFG_RESET;
        end else if (i_cfg_we && i_cfg_idx <= aat_pkg::CFG_LAST) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // stage enables: a stage loads when empty or when its successor moves
    assign en_o = !r_vo || o_box.ready;
    assign en3  = !r_v3 || en_o;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;
    assign i_box.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)  r_v1 <= i_box.valid;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en_o) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_lo[0] <= i_box.in_lower_x;
            r_lo[1] <= i_box.in_lower_y;
            r_lo[2] <= i_box.in_lower_z;
            r_hi[0] <= i_box.in_upper_x;
            r_hi[1] <= i_box.in_upper_y;
            r_hi[2] <= i_box.in_upper_z;
        end
    end

    for (genvar r = 0; r < N; r++) begin : g_row
        aat_pkg::t_q16  coef [N];
        aat_pkg::t_prod p_lo [N];
        aat_pkg::t_prod p_hi [N];
        aat_pkg::t_q16  trans;

        assign coef[0] = r_cfg[2*r][31:0];
        assign coef[1] = r_cfg[2*r][63:32];
        assign coef[2] = r_cfg[2*r+1][31:0];
        assign trans   = r_cfg[2*r+1][63:32];

        aat_row_mul u_mul (
            .i_clk  (i_clk),
            .i_en   (en2),
            .i_coef (coef),
            .i_lo   (r_lo),
            .i_hi   (r_hi),
            .o_p_lo (p_lo),
            .o_p_hi (p_hi)
        );

        aat_row_bound u_bound (
            .i_clk     (i_clk),
            .i_en      (en3),
            .i_p_lo    (p_lo),
            .i_p_hi    (p_hi),
            .o_min_sum (min_sum[r]),
            .o_max_sum (max_sum[r])
        );

        // translation enters after the shift, w is 1.0
        always_ff @(posedge i_clk) begin
            if (en_o) begin
                r_out_lo[r] <= aat_pkg::floor_sat(min_sum[r], trans);
                r_out_hi[r] <= aat_pkg::floor_sat(max_sum[r], trans);
            end
        end
    end

    assign o_box.valid       = r_vo;
    assign o_box.out_lower_x = r_out_lo[0];
    assign o_box.out_lower_y = r_out_lo[1];
    assign o_box.out_lower_z = r_out_lo[2];
    assign o_box.out_upper_x = r_out_hi[0];
    assign o_box.out_upper_y = r_out_hi[1];
    assign o_box.out_upper_z = r_out_hi[2];

`ifndef SYNTHESIS
    logic [2:0] occ;
    logic       acc_in, del_out;
    assign occ     = 3'($countones({r_v1, r_v2, r_v3, r_vo}));
    assign acc_in  = i_box.valid && i_box.ready;
    assign del_out = o_box.valid && o_box.ready;

    // items in flight change only by input and output transfers
    a_occ_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            occ == 3'($past(occ) + 3'($past(acc_in)) - 3'($past(del_out))))
        else $error("pipeline occupancy mismatch");

    // any bubble in the pipeline must let a new box in
    a_ready_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ != 3'd4 |-> i_box.ready)
        else $error("input stalled with a free stage");

    // bounding box is always ordered
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.valid |-> (o_box.out_lower_x <= o_box.out_upper_x) &&
                        (o_box.out_lower_y <= o_box.out_upper_y) &&
                        (o_box.out_lower_z <= o_box.out_upper_z))
        else $error("output box not ordered");
`endif

endmodule

>>> hdl/aat_row_mul.sv
// Product stage for one output row: coefficient times lower and upper coordinate.
// Depends on aat_pkg.
module aat_row_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  aat_pkg::t_q16 i_coef  [aat_pkg::NUM_AXES],
    input  aat_pkg::t_q16 i_lo    [aat_pkg::NUM_AXES],
    input  aat_pkg::t_q16 i_hi    [aat_pkg::NUM_AXES],
    output aat_pkg::t_prod o_p_lo [aat_pkg::NUM_AXES],
    output aat_pkg::t_prod o_p_hi [aat_pkg::NUM_AXES]
);

    aat_pkg::t_prod r_p_lo [aat_pkg::NUM_AXES];
    aat_pkg::t_prod r_p_hi [aat_pkg::NUM_AXES];
    aat_pkg::t_prod n_p_lo [aat_pkg::NUM_AXES];
    aat_pkg::t_prod n_p_hi [aat_pkg::NUM_AXES];

    always_comb begin
        for (int k = 0; k < aat_pkg::NUM_AXES; k++) begin
            n_p_lo[k] = aat_pkg::t_prod'(i_coef[k]) * aat_pkg::t_prod'(i_lo[k]);
            n_p_hi[k] = aat_pkg::t_prod'(i_coef[k]) * aat_pkg::t_prod'(i_hi[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo <= n_p_lo;
            r_p_hi <= n_p_hi;
        end
    end

    assign o_p_lo = r_p_lo;
    assign o_p_hi = r_p_hi;

endmodule

>>> hdl/aat_row_bound.sv
// Bound stage for one output row: per-column min/max of the products, summed.
// Depends on aat_pkg.
module aat_row_bound (
    input  logic           i_clk,
    input  logic           i_en,
    input  aat_pkg::t_prod i_p_lo [aat_pkg::NUM_AXES],
    input  aat_pkg::t_prod i_p_hi [aat_pkg::NUM_AXES],
    output aat_pkg::t_sum  o_min_sum,
    output aat_pkg::t_sum  o_max_sum
);

    aat_pkg::t_sum r_min_sum;
    aat_pkg::t_sum r_max_sum;
    aat_pkg::t_sum n_min_sum;
    aat_pkg::t_sum n_max_sum;

    // Each column picks independently, so the sums bound all eight corners.
    always_comb begin
        n_min_sum = '0;
        n_max_sum = '0;
        for (int k = 0; k < aat_pkg::NUM_AXES; k++) begin
            if (i_p_lo[k] < i_p_hi[k]) begin
                n_min_sum = n_min_sum + aat_pkg::t_sum'(i_p_lo[k]);
                n_max_sum = n_max_sum + aat_pkg::t_sum'(i_p_hi[k]);
            end else begin
                n_min_sum = n_min_sum + aat_pkg::t_sum'(i_p_hi[k]);
                n_max_sum = n_max_sum + aat_pkg::t_sum'(i_p_lo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_min_sum <= n_min_sum;
            r_max_sum <= n_max_sum;
        end
    end

    assign o_min_sum = r_min_sum;
    assign o_max_sum = r_max_sum;

endmodule

>>> tb/aabb_affine_transform_test.sv
`timescale 1ns / 100ps
// Self-checking bench for aabb_affine_transform: directed and random boxes under several affine maps.
// Depends on aat_pkg, aat_in_if, aat_out_if and the block's sources in hdl/.
module aabb_affine_transform_test;

    typedef aat_pkg::t_q16 t_q16;
    typedef aat_pkg::t_cfg t_cfg;

    typedef struct packed {
        t_q16 lo_x, lo_y, lo_z;
        t_q16 hi_x, hi_y, hi_z;
    } t_box;

    localparam t_q16 Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q16 Q_MIN = 32'sh8000_0000;
    localparam t_q16 Q_ONE = 32'sh0001_0000;
    localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
    localparam logic signed [79:0] SAT_LO = -80'sd2147483648;
    localparam int PIPE_SLACK = 8;
    localparam int RAND_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 113;

    localparam logic [aat_pkg::CFG_IDX_W-1:0] ROW_COLS01 [3] = '{
        aat_pkg::CFG_ROW0_COLS01, aat_pkg::CFG_ROW1_COLS01, aat_pkg::CFG_ROW2_COLS01
    };
    localparam logic [aat_pkg::CFG_IDX_W-1:0] ROW_COLS23 [3] = '{
        aat_pkg::CFG_ROW0_COLS23, aat_pkg::CFG_ROW1_COLS23, aat_pkg::CFG_ROW2_COLS23
    };
    // indexes past the map, writes there must be dropped
    localparam logic [aat_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = aat_pkg::CFG_LAST + 3'd1;
    localparam logic [aat_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = aat_pkg::CFG_LAST + 3'd2;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [aat_pkg::CFG_IDX_W-1:0]   cfg_idx;
    t_cfg                            cfg_data;

    aat_in_if  box_in ();
    aat_out_if box_out ();

    aabb_affine_transform DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_box      (box_in),
        .o_box      (box_out)
    );

    t_cfg  map_reg [6];
    t_box  pending_boxes [$];
    t_box  expected_bounds [$];
    int    errors;
    string field_name [6] = '{"out_lower_x", "out_lower_y", "out_lower_z",
                              "out_upper_x", "out_upper_y", "out_upper_z"};

    logic  in_xfer, out_xfer;
    int    in_gap, in_calm_left, out_stall, out_calm_left;
    bit    in_calm, out_calm;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // One bound of one output axis over the eight corners, exact sum then floor and clamp.
    function automatic t_q16 axis_extent(input int row, input t_box b, input bit want_max);
        t_q16                c [4];
        t_q16                lo [3];
        t_q16                hi [3];
        aat_pkg::t_prod      pa, pb, p;
        logic signed [79:0]  acc;
        acc   = '0;
        c[0]  = map_reg[2*row][31:0];
        c[1]  = map_reg[2*row][63:32];
        c[2]  = map_reg[2*row+1][31:0];
        c[3]  = map_reg[2*row+1][63:32];
        lo[0] = b.lo_x; lo[1] = b.lo_y; lo[2] = b.lo_z;
        hi[0] = b.hi_x; hi[1] = b.hi_y; hi[2] = b.hi_z;
        for (int k = 0; k < 3; k++) begin
            pa = aat_pkg::t_prod'(c[k]) * aat_pkg::t_prod'(lo[k]);
            pb = aat_pkg::t_prod'(c[k]) * aat_pkg::t_prod'(hi[k]);
            if (want_max) p = (pa > pb) ? pa : pb;
            else          p = (pa < pb) ? pa : pb;
            acc = acc + 80'(p);
        end
        acc = (acc >>> 16) + 80'(c[3]);
        if (acc > SAT_HI) acc = SAT_HI;
        if (acc < SAT_LO) acc = SAT_LO;
        return acc[31:0];
    endfunction

    function automatic t_box transformed_bounds(input t_box b);
        t_box r;
        r.lo_x = axis_extent(0, b, 1'b0);
        r.lo_y = axis_extent(1, b, 1'b0);
        r.lo_z = axis_extent(2, b, 1'b0);
        r.hi_x = axis_extent(0, b, 1'b1);
        r.hi_y = axis_extent(1, b, 1'b1);
        r.hi_z = axis_extent(2, b, 1'b1);
        return r;
    endfunction

    function automatic int pick_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic t_q16 pick_coeff();
        int v;
        v = $urandom_range(0, 524287) - 262144;
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            5, 6:    return t_q16'($urandom);
            default: return t_q16'(v);
        endcase
    endfunction

    function automatic t_q16 pick_coord();
        int v;
        v = $urandom_range(0, 33554431) - 16777216;
        case ($urandom_range(0, 9))
            0:             return Q_MAX;
            1:             return Q_MIN;
            2:             return '0;
            3, 4, 5, 6:    return t_q16'($urandom);
            default:       return t_q16'(v);
        endcase
    endfunction

    function automatic t_box random_box();
        t_q16 lo [3];
        t_q16 hi [3];
        t_q16 t;
        bit   ordered;
        ordered = ($urandom_range(0, 9) < 6);
        for (int k = 0; k < 3; k++) begin
            lo[k] = pick_coord();
            hi[k] = ($urandom_range(0, 15) == 0) ? lo[k] : pick_coord();
            if (ordered && lo[k] > hi[k]) begin
                t = lo[k]; lo[k] = hi[k]; hi[k] = t;
            end
        end
        return t_box'{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    endfunction

    task automatic write_reg(input logic [aat_pkg::CFG_IDX_W-1:0] idx, input t_cfg val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx <= aat_pkg::CFG_LAST) map_reg[idx] = val;
    endtask

    task automatic write_row(input int row, input t_q16 c0, input t_q16 c1, input t_q16 c2,
                             input t_q16 tr);
        write_reg(ROW_COLS01[row], {c1, c0});
        write_reg(ROW_COLS23[row], {tr, c2});
    endtask

    // waits until every box has been sent and every bound has come back
    task automatic wait_drained();
        do @(posedge clk);
        while (pending_boxes.size() != 0 || box_in.valid || expected_bounds.size() != 0);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // Input side: new box presented at the falling edge after a random gap.
    always @(negedge clk) begin : drive_boxes
        logic nv;
        t_box nxt;
        nv = box_in.valid;
        if (rst_n) begin
            if (box_in.valid && in_xfer) begin
                nv = 1'b0;
                if (in_calm_left == 0) begin
                    in_calm      = ($urandom_range(0, 3) == 0);
                    in_calm_left = $urandom_range(10, 60);
                end else begin
                    in_calm_left--;
                end
                in_gap = pick_wait(in_calm);
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_boxes.size() != 0) begin
                    nxt = pending_boxes.pop_front();
                    box_in.in_lower_x <= nxt.lo_x;
                    box_in.in_lower_y <= nxt.lo_y;
                    box_in.in_lower_z <= nxt.lo_z;
                    box_in.in_upper_x <= nxt.hi_x;
                    box_in.in_upper_y <= nxt.hi_y;
                    box_in.in_upper_z <= nxt.hi_z;
                    nv = 1'b1;
                end
            end
        end
        box_in.valid <= nv;
    end

    // Output side: ready dropped for a random stall after each transfer.
    always @(negedge clk) begin : drive_ready
        logic nr;
        nr = box_out.ready;
        if (rst_n) begin
            if (out_xfer) begin
                if (out_calm_left == 0) begin
                    out_calm      = ($urandom_range(0, 3) == 0);
                    out_calm_left = $urandom_range(10, 60);
                end else begin
                    out_calm_left--;
                end
                out_stall = pick_wait(out_calm);
            end
            if (out_stall > 0) begin
                out_stall--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
        end
        box_out.ready <= nr;
    end

    always @(posedge clk) begin : watch_ports
        t_box got, want;
        in_xfer  <= box_in.valid && box_in.ready;
        out_xfer <= box_out.valid && box_out.ready;
        if (rst_n && box_in.valid && box_in.ready) begin
            expected_bounds.push_back(transformed_bounds(t_box'{
                box_in.in_lower_x, box_in.in_lower_y, box_in.in_lower_z,
                box_in.in_upper_x, box_in.in_upper_y, box_in.in_upper_z}));
        end
        if (rst_n && box_out.valid && box_out.ready) begin
            got = t_box'{box_out.out_lower_x, box_out.out_lower_y, box_out.out_lower_z,
                         box_out.out_upper_x, box_out.out_upper_y, box_out.out_upper_z};
            if (expected_bounds.size() == 0) begin
                $error("bounding box transfer with no box outstanding");
                errors++;
            end else begin
                want = expected_bounds.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (got[191-32*i -: 32] !== want[191-32*i -: 32]) begin
                        $error("%s: expected %0d, actual %0d", field_name[i],
                               $signed(want[191-32*i -: 32]), $signed(got[191-32*i -: 32]));
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("aabb_affine_transform verification failed");
        $finish;
    end

    initial begin
        t_q16 c [4];
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        box_in.valid      = 1'b0;
        box_in.in_lower_x = '0;
        box_in.in_lower_y = '0;
        box_in.in_lower_z = '0;
        box_in.in_upper_x = '0;
        box_in.in_upper_y = '0;
        box_in.in_upper_z = '0;
        box_out.ready     = 1'b0;
        in_xfer = 1'b0; out_xfer = 1'b0;
        in_gap = 0; in_calm = 1'b0; in_calm_left = 0;
        out_stall = 0; out_calm = 1'b0; out_calm_left = 0;
        errors = 0;
        // identity map expected out of reset
        map_reg[aat_pkg::CFG_ROW0_COLS01] = {32'h0, 32'h0001_0000};
        map_reg[aat_pkg::CFG_ROW0_COLS23] = '0;
        map_reg[aat_pkg::CFG_ROW1_COLS01] = {32'h0001_0000, 32'h0};
        map_reg[aat_pkg::CFG_ROW1_COLS23] = '0;
        map_reg[aat_pkg::CFG_ROW2_COLS01] = '0;
        map_reg[aat_pkg::CFG_ROW2_COLS23] = {32'h0, 32'h0001_0000};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity: extremes, inverted boxes, negative fractions
        pending_boxes.push_back(t_box'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0});
        pending_boxes.push_back(t_box'{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX});
        pending_boxes.push_back(t_box'{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN});
        pending_boxes.push_back(t_box'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX});
        pending_boxes.push_back(t_box'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN});
        pending_boxes.push_back(t_box'{32'shFFFE_8000, 32'sh0, 32'sh1, 32'sh0002_4000,
                                       32'sh0000_0001, 32'sh7});
        pending_boxes.push_back(t_box'{32'sh1000, 32'sh5_0000, -32'sh1, 32'sh2000,
                                       -32'sh5_0000, 32'sh1});
        wait_drained();

        // rounding and clamping on every row
        write_row(0, 32'sh0000_8000, 32'shFFFF_4000, 32'sh0000_0001, 32'shFFFC_8000);
        write_row(1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        write_row(2, Q_MIN, Q_MIN, 32'sh0, Q_MIN);
        pending_boxes.push_back(t_box'{32'sh1, -32'sh1, 32'sh3, 32'sh1_8001, -32'sh7FFF,
                                       32'sh5});
        pending_boxes.push_back(t_box'{-32'sh3, 32'sh3, -32'sh1_0001, -32'sh1, 32'sh1_0003,
                                       32'sh0});
        pending_boxes.push_back(t_box'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX});
        pending_boxes.push_back(t_box'{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX});
        pending_boxes.push_back(t_box'{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN});
        pending_boxes.push_back(t_box'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0});
        for (int i = 0; i < 4; i++) pending_boxes.push_back(random_box());
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int row = 0; row < 3; row++) begin
                for (int k = 0; k < 4; k++) begin
                    case (p)
                        0:       c[k] = Q_MAX;
                        1:       c[k] = Q_MIN;
                        2:       c[k] = (k == 3) ? ((row == 1) ? Q_MIN : Q_MAX) : 32'sh0;
                        default: c[k] = pick_coeff();
                    endcase
                end
                write_row(row, c[0], c[1], c[2], c[3]);
            end
            if (p == 4) begin
                write_reg(CFG_SPARE_A, {$urandom, $urandom});
                write_reg(CFG_SPARE_B, {$urandom, $urandom});
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_boxes.push_back(random_box());
            wait_drained();
        end

        if (errors == 0) begin
            $display("aabb_affine_transform verification clean");
        end else begin
            $display("aabb_affine_transform verification failed");
        end
        $finish;
    end

endmodule
